@@ hw/rtl/triangle_tangent_calculator_top_assert.svh @@
// Assertion macros for the triangle tangent calculator.
`ifndef TRIANGLE_TANGENT_CALCULATOR_TOP_ASSERT_SVH
`define TRIANGLE_TANGENT_CALCULATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define TTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tangent calculator assertion failed");

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define TTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tangent calculator assertion failed");

`endif

@@ hw/rtl/ttc_pkg.sv @@
// Shared types and constants of the triangle tangent calculator.
package ttc_pkg;

  localparam int unsigned PW  = 32;        // position width
  localparam int unsigned TW  = 24;        // texture coordinate and scale width
  localparam int unsigned EW  = PW + 1;    // edge vector width
  localparam int unsigned UW  = TW + 1;    // uv delta width
  localparam int unsigned PPW = 2 * UW;    // uv delta product width
  localparam int unsigned GW  = PPW + 1;   // determinant width
  localparam int unsigned GLW = 26;        // low slice of |g| per partial product
  localparam int unsigned GHW = GW - GLW;  // high slice of |g|
  localparam int unsigned MW  = UW + EW;   // numerator product width
  localparam int unsigned NW  = MW + 1;    // numerator width
  localparam int unsigned DW  = TW + GW;   // divisor width
  localparam int unsigned QW  = 33;        // quotient width
  localparam int unsigned OW  = 32;        // tangent width
  localparam int unsigned QSTEPS = 32;     // quotient bits below the integer one
  localparam int unsigned BCW = $clog2(QSTEPS);

  localparam int unsigned IN_DW  = 3 * PW + 2 * TW;
  localparam int unsigned OUT_DW = 3 * OW;
  localparam int unsigned CIW    = 2;

  localparam int unsigned FIFO_DEPTH_DEF = 2;

  localparam logic [TW-1:0] UV_SCALE_RST = TW'(65536);
  localparam logic [QW-1:0] Q_OVER       = QW'(64'h1_0000_0000);
  localparam logic [QW-1:0] Q_NEG_MAX    = QW'(64'h0_8000_0000);
  localparam logic [QW-1:0] Q_POS_MAX    = QW'(64'h0_7FFF_FFFF);

  // Configuration register indexes.
  typedef enum logic [CIW-1:0] {
    REG_UV_SCALE  = 2'd0,
    REG_UV_OFFSET = 2'd1,
    REG_WINDING   = 2'd2
  } cfg_reg_e;

  // One triangle handed from the front to the back.
  typedef struct packed {
    logic [2:0][EW-1:0] e1;
    logic [2:0][EW-1:0] e2;
    logic [UW-1:0]      du1;
    logic [UW-1:0]      dv1;
    logic [UW-1:0]      du2;
    logic [UW-1:0]      dv2;
    logic [TW-1:0]      scale;
  } job_t;

endpackage

@@ hw/rtl/triangle_tangent_calculator_top.sv @@
// A triangle with a zero uv determinant or a zero scale skips the divider, and so does
// each axis whose quotient saturates.
// Throughput: one vertex per cycle while the triangle queue has room; the back end takes
// one triangle at a time, using the one-bit-per-cycle divider for each axis in turn.
// Reset (rst_ni low, asynchronous): corner count, queue and output valid clear,
// uv_scale returns to 1.0 and winding to counter-clockwise.
module triangle_tangent_calculator_top #(
  parameter int unsigned FifoDepth = ttc_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], tex_u [119:96], tex_v [143:120]
  input  logic [ttc_pkg::IN_DW-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // tangent_x [31:0], tangent_y [63:32], tangent_z [95:64]
  output logic [ttc_pkg::OUT_DW-1:0] m_axis_tdata_o,
  // degenerate [0]
  output logic                       m_axis_tuser_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ttc_pkg::CIW-1:0]    cfg_index_i,
  input  logic [ttc_pkg::TW-1:0]     cfg_data_i
);
  import ttc_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  job_t q_wr, q_rd;

  assign cfg_ready_o = 1'b1;

  // Collect vertices and form triangle requests.
  ttc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_valid_i (s_axis_tvalid_i),
    .vtx_ready_o (s_axis_tready_o),
    .pos_x_i     (s_axis_tdata_i[PW-1:0]),
    .pos_y_i     (s_axis_tdata_i[2*PW-1:PW]),
    .pos_z_i     (s_axis_tdata_i[3*PW-1:2*PW]),
    .tex_u_i     (s_axis_tdata_i[3*PW+TW-1:3*PW]),
    .tex_v_i     (s_axis_tdata_i[3*PW+2*TW-1:3*PW+TW]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wr)
  );

  // Queue triangle requests.
  ttc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr),
    .pop_i     (q_pop),
    .rd_data_o (q_rd),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // Compute tangents.
  ttc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_data_i         (q_rd),
    .q_pop_o          (q_pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_tangent_o    (m_axis_tdata_o),
    .out_degenerate_o (m_axis_tuser_o)
  );

endmodule

@@ hw/rtl/ttc_fifo.sv @@
// Short triangle queue between the front and the back.
module ttc_fifo #(
  parameter int unsigned Depth = ttc_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttc_pkg::job_t wr_data_i,
  input  logic          pop_i,
  output ttc_pkg::job_t rd_data_o,
  output logic          full_o,
  output logic          empty_o
);
  import ttc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Store a pushed triangle.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/ttc_front.sv @@
// Vertex collection, configuration registers and edge/delta formation.
module ttc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vtx_valid_i,
  output logic                    vtx_ready_o,
  input  logic [ttc_pkg::PW-1:0]  pos_x_i,
  input  logic [ttc_pkg::PW-1:0]  pos_y_i,
  input  logic [ttc_pkg::PW-1:0]  pos_z_i,
  input  logic [ttc_pkg::TW-1:0]  tex_u_i,
  input  logic [ttc_pkg::TW-1:0]  tex_v_i,
  input  logic                    cfg_valid_i,
  input  logic [ttc_pkg::CIW-1:0] cfg_index_i,
  input  logic [ttc_pkg::TW-1:0]  cfg_data_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output ttc_pkg::job_t           q_data_o
);
  import ttc_pkg::*;

  logic [1:0]    corner_q;
  logic [TW-1:0] uv_scale_q;
  logic          winding_q;
  logic [PW-1:0] held_pos_q [2][3];
  logic [TW-1:0] held_u_q [2];
  logic [TW-1:0] held_v_q [2];
  logic [PW-1:0] pos [3];
  logic [EW-1:0] eb [3];
  logic [EW-1:0] ec [3];
  logic [UW-1:0] bu, bv, cu, cv;
  logic          accept, third;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  assign third       = (corner_q == 2'd2);
  assign vtx_ready_o = !third || !q_full_i;
  assign accept      = vtx_valid_i && vtx_ready_o;
  assign q_push_o    = accept && third;

  // Form edges and uv deltas against the held corners.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eb[i] = EW'($signed(held_pos_q[1][i])) - EW'($signed(held_pos_q[0][i]));
      ec[i] = EW'($signed(pos[i])) - EW'($signed(held_pos_q[0][i]));
    end
    bu = UW'($signed(held_u_q[1])) - UW'($signed(held_u_q[0]));
    bv = UW'($signed(held_v_q[1])) - UW'($signed(held_v_q[0]));
    cu = UW'($signed(tex_u_i)) - UW'($signed(held_u_q[0]));
    cv = UW'($signed(tex_v_i)) - UW'($signed(held_v_q[0]));
  end

  // Order by winding and capture the scale of this triangle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_data_o.e1[i] = winding_q ? ec[i] : eb[i];
      q_data_o.e2[i] = winding_q ? eb[i] : ec[i];
    end
    q_data_o.du1   = winding_q ? cu : bu;
    q_data_o.dv1   = winding_q ? cv : bv;
    q_data_o.du2   = winding_q ? bu : cu;
    q_data_o.dv2   = winding_q ? bv : cv;
    q_data_o.scale = uv_scale_q;
  end

  // Hold corners A and B.
  always_ff @(posedge clk_i) begin
    if (accept && !third) begin
      for (int i = 0; i < 3; i++) begin
        held_pos_q[corner_q[0]][i] <= pos[i];
      end
      held_u_q[corner_q[0]] <= tex_u_i;
      held_v_q[corner_q[0]] <= tex_v_i;
    end
  end

  // Count corners and take configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q   <= 2'd0;
      uv_scale_q <= UV_SCALE_RST;
      winding_q  <= 1'b0;
    end else begin
      if (accept) begin
        corner_q <= third ? 2'd0 : corner_q + 2'd1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_UV_SCALE: uv_scale_q <= cfg_data_i;
          REG_UV_OFFSET: begin
            // The offset cancels in every delta: accept and drop.
          end
          REG_WINDING:  winding_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ hw/rtl/ttc_back.sv @@
// Tangent sequencer: determinant, divisor and a shared restoring divider.
module ttc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  ttc_pkg::job_t              q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ttc_pkg::OUT_DW-1:0] out_tangent_o,
  output logic                       out_degenerate_o
);
  import ttc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_GMUL = 10'b00_0000_0010,
    ST_GSUB = 10'b00_0000_0100,
    ST_DMUL = 10'b00_0000_1000,
    ST_DSUM = 10'b00_0001_0000,
    ST_NMUL = 10'b00_0010_0000,
    ST_NSUB = 10'b00_0100_0000,
    ST_DIV  = 10'b00_1000_0000,
    ST_RND  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [1:0]     comp_q;
  logic [BCW-1:0] bit_q;
  logic           out_valid_q;

  job_t                  job_q;
  logic signed [PPW-1:0] pa_q, pb_q;
  logic signed [GW-1:0]  g_q;
  logic [TW+GLW-1:0]     plo_q;
  logic [TW+GHW-1:0]     phi_q;
  logic [DW-1:0]         d_q;
  logic signed [MW-1:0]  ma_q, mb_q;
  logic [DW-1:0]         r_q;
  logic [QW-1:0]         q_q;
  logic                  neg_q, deg_q;
  logic [OW-1:0]         res_q [3];
  logic [OUT_DW-1:0]     out_tan_q;
  logic                  out_deg_q;

  logic signed [GW-1:0] g;
  logic [GW-1:0]        gmag;
  logic [TW-1:0]        smag;
  logic signed [NW-1:0] n;
  logic [NW-1:0]        nmag;
  logic [DW:0]          r2, dx;
  logic                 ge, nsat;
  logic [QW-1:0]        qr, qs;
  logic [OW-1:0]        res;
  logic                 out_load;

  assign q_pop_o          = (state_q == ST_IDLE) && !q_empty_i;
  assign out_load         = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o      = out_valid_q;
  assign out_tangent_o    = out_tan_q;
  assign out_degenerate_o = out_deg_q;

  // Datapath helpers.
  always_comb begin
    g    = GW'(pa_q) - GW'(pb_q);
    gmag = g_q[GW-1] ? GW'(-g_q) : GW'(g_q);
    smag = job_q.scale[TW-1] ? TW'(-$signed(job_q.scale)) : job_q.scale;
    n    = NW'(ma_q) - NW'(mb_q);
    nmag = n[NW-1] ? NW'(-n) : NW'(n);
    nsat = (DW'(nmag) >= d_q);
    r2   = {r_q, 1'b0};
    dx   = {1'b0, d_q};
    ge   = (r2 >= dx);
    qr   = q_q + QW'(ge);
    if (neg_q) begin
      qs  = (qr > Q_NEG_MAX) ? Q_NEG_MAX : qr;
      res = OW'(-qs[OW-1:0]);
    end else begin
      qs  = (qr > Q_POS_MAX) ? Q_POS_MAX : qr;
      res = qs[OW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_GMUL;
      ST_GMUL: state_d = ST_GSUB;
      ST_GSUB: state_d = ((g == '0) || (job_q.scale == '0)) ? ST_OUT : ST_DMUL;
      ST_DMUL: state_d = ST_DSUM;
      ST_DSUM: state_d = ST_NMUL;
      ST_NMUL: state_d = ST_NSUB;
      ST_NSUB: state_d = nsat ? ST_RND : ST_DIV;
      ST_DIV:  if (bit_q == '0) state_d = ST_RND;
      ST_RND:  state_d = (comp_q == 2'd2) ? ST_OUT : ST_NMUL;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      comp_q      <= 2'd0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DSUM) begin
        comp_q <= 2'd0;
      end else if (state_q == ST_RND) begin
        comp_q <= comp_q + 2'd1;
      end
      if (state_q == ST_NSUB) begin
        bit_q <= BCW'(QSTEPS - 1);
      end else if (state_q == ST_DIV) begin
        bit_q <= bit_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_data_i;
    end
    case (state_q)
      ST_GMUL: begin
        pa_q <= PPW'($signed(job_q.dv1) * $signed(job_q.du2));
        pb_q <= PPW'($signed(job_q.du1) * $signed(job_q.dv2));
      end
      ST_GSUB: begin
        g_q   <= g;
        deg_q <= (g == '0) || (job_q.scale == '0);
        for (int i = 0; i < 3; i++) begin
          res_q[i] <= '0;
        end
      end
      ST_DMUL: begin
        plo_q <= smag * gmag[GLW-1:0];
        phi_q <= smag * gmag[GW-1:GLW];
      end
      ST_DSUM: d_q <= DW'(plo_q) + {phi_q, {GLW{1'b0}}};
      ST_NMUL: begin
        ma_q <= MW'($signed(job_q.dv1) * $signed(job_q.e2[comp_q]));
        mb_q <= MW'($signed(job_q.dv2) * $signed(job_q.e1[comp_q]));
      end
      ST_NSUB: begin
        neg_q <= n[NW-1] ^ job_q.scale[TW-1] ^ g_q[GW-1];
        if (nsat) begin
          q_q <= Q_OVER;
          r_q <= '0;
        end else begin
          q_q <= '0;
          r_q <= DW'(nmag);
        end
      end
      ST_DIV: begin
        r_q <= ge ? DW'(r2 - dx) : DW'(r2);
        q_q <= {q_q[QW-2:0], ge};
      end
      ST_RND: res_q[comp_q] <= res;
      default: begin
      end
    endcase
    if (out_load) begin
      out_tan_q <= {res_q[2], res_q[1], res_q[0]};
      out_deg_q <= deg_q;
    end
  end

endmodule

@@ hw/rtl/ttc_checker.sv @@
// Port-level checks of the triangle tangent calculator, bound to the top level.
`include "triangle_tangent_calculator_top_assert.svh"

module ttc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [ttc_pkg::OUT_DW-1:0] m_axis_tdata_o,
  input logic                       m_axis_tuser_o,
  input logic                       cfg_ready_o
);

  // A stalled result holds.
  `TTC_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // A degenerate triangle carries a zero tangent.
  `TTC_ASSERT_IMP(a_deg_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0)

  // Configuration writes are always taken.
  `TTC_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready_o)

endmodule

bind triangle_tangent_calculator_top ttc_checker u_ttc_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking stream testbench for the triangle tangent calculator.
module tb_top;
  import ttc_pkg::*;

  typedef struct packed {
    logic [TW-1:0] tv;
    logic [TW-1:0] tu;
    logic [PW-1:0] pz;
    logic [PW-1:0] py;
    logic [PW-1:0] px;
  } vertex_t;

  typedef struct {
    logic [OW-1:0] tx;
    logic [OW-1:0] ty;
    logic [OW-1:0] tz;
    logic          degen;
  } tangent_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_DW-1:0]  s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata_o;
  logic              m_axis_tuser_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIW-1:0]    cfg_index_i = '0;
  logic [TW-1:0]     cfg_data_i = '0;

  triangle_tangent_calculator_top dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [PW-1:0] held_pos [6];
  logic signed [TW-1:0] held_uv [4];
  int unsigned          corners;
  logic signed [TW-1:0] scale_cfg;
  logic signed [TW-1:0] offset_cfg;
  logic                 cw_cfg;

  vertex_t  vertex_q [$];
  tangent_t tangent_q [$];
  int       mismatches = 0;
  int       accepted = 0;
  int       results = 0;
  int       cycles = 0;
  bit       took_vertex = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_cnt = 0;
  bit       hold_done = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Round n * 2^32 / (s * g) to nearest, halves away from zero, saturate to Q16.16.
  function automatic logic [OW-1:0] tangent_axis(longint n, longint s, longint g);
    logic [191:0] num, den, quo, rem;
    bit neg;
    neg = (n < 0) != ((s < 0) != (g < 0));
    num = 192'(n < 0 ? -n : n) << 32;
    den = 192'(s < 0 ? -s : s) * 192'(g < 0 ? -g : g);
    quo = num / den;
    rem = num % den;
    if (quo < (192'(1) << 32) && (rem << 1) >= den) quo = quo + 1;
    if (neg) begin
      if (quo > 192'h8000_0000) quo = 192'h8000_0000;
      return OW'(-quo);
    end
    if (quo > 192'h7FFF_FFFF) quo = 192'h7FFF_FFFF;
    return OW'(quo);
  endfunction

  // Hold corners A and B; on C queue the expected tangent.
  task automatic predict_vertex(vertex_t v);
    longint bu, bv, cu, cv, du1, dv1, du2, dv2, g, b, c;
    longint e1 [3];
    longint e2 [3];
    logic signed [PW-1:0] p [3];
    tangent_t t;
    p[0] = v.px; p[1] = v.py; p[2] = v.pz;
    if (corners < 2) begin
      for (int i = 0; i < 3; i++) held_pos[corners*3 + i] = p[i];
      held_uv[corners*2] = v.tu;
      held_uv[corners*2 + 1] = v.tv;
      corners++;
      return;
    end
    corners = 0;
    bu = longint'(held_uv[2]) - held_uv[0];
    bv = longint'(held_uv[3]) - held_uv[1];
    cu = longint'($signed(v.tu)) - held_uv[0];
    cv = longint'($signed(v.tv)) - held_uv[1];
    for (int i = 0; i < 3; i++) begin
      b = longint'(held_pos[3 + i]) - held_pos[i];
      c = longint'(p[i]) - held_pos[i];
      e1[i] = cw_cfg ? c : b;
      e2[i] = cw_cfg ? b : c;
    end
    du1 = cw_cfg ? cu : bu;
    dv1 = cw_cfg ? cv : bv;
    du2 = cw_cfg ? bu : cu;
    dv2 = cw_cfg ? bv : cv;
    g = dv1 * du2 - du1 * dv2;
    if (g == 0 || scale_cfg == 0) begin
      t = '{tx: '0, ty: '0, tz: '0, degen: 1'b1};
    end else begin
      t.tx = tangent_axis(dv1 * e2[0] - dv2 * e1[0], scale_cfg, g);
      t.ty = tangent_axis(dv1 * e2[1] - dv2 * e1[1], scale_cfg, g);
      t.tz = tangent_axis(dv1 * e2[2] - dv2 * e1[2], scale_cfg, g);
      t.degen = 1'b0;
    end
    tangent_q = {tangent_q, t};
  endtask

  // Sample requests on all three channels at the rising edge.
  always @(posedge clk_i) begin
    tangent_t t;
    cycles <= cycles + 1;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_UV_SCALE:  scale_cfg = cfg_data_i;
        REG_UV_OFFSET: offset_cfg = cfg_data_i;
        REG_WINDING:   cw_cfg = cfg_data_i[0];
        default: ;
      endcase
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_vertex(vertex_t'(s_axis_tdata_i));
      took_vertex <= 1'b1;
      accepted <= accepted + 1;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results <= results + 1;
      if (tangent_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tangent %h", m_axis_tdata_o);
      end else begin
        t = tangent_q.pop_front();
        if (m_axis_tdata_o != {t.tz, t.ty, t.tx} || m_axis_tuser_o != t.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tangent mismatch: exp %h/%h/%h deg %b, got %h/%h/%h deg %b",
                     t.tx, t.ty, t.tz, t.degen, m_axis_tdata_o[31:0],
                     m_axis_tdata_o[63:32], m_axis_tdata_o[95:64], m_axis_tuser_o);
        end
      end
    end
  end

  // Vertex driver: advance on acceptance, insert random gaps.
  always @(negedge clk_i) begin
    if (took_vertex) begin
      void'(vertex_q.pop_front());
      took_vertex <= 1'b0;
      send_gap = pick_gap();
    end
    if (send_gap > 0 || vertex_q.size() == 0) begin
      if (send_gap > 0) send_gap--;
      s_axis_tvalid_i <= 1'b0;
    end else begin
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i <= vertex_q[0];
    end
  end

  // Long receiver hold-off once, while vertices keep coming.
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted >= 300) begin
      hold_done <= 1'b1;
      hold_cnt <= 2000;
    end
  end

  // Result receiver: random stalls, drop ready during the hold-off.
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (m_axis_tready_i && m_axis_tvalid_o) recv_gap = pick_gap();
    end
  end

  // End the run on a stuck block.
  always @(posedge clk_i) begin
    if (cycles > 600000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [TW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic vertex_t rand_vertex(bit small_uv);
    vertex_t v;
    v.px = $urandom; v.py = $urandom; v.pz = $urandom;
    if (small_uv) begin
      v.tu = TW'($urandom_range(0, 262143)) - TW'(131072);
      v.tv = TW'($urandom_range(0, 262143)) - TW'(131072);
    end else begin
      v.tu = TW'($urandom);
      v.tv = TW'($urandom);
    end
    return v;
  endfunction

  task automatic push_tri(vertex_t a, vertex_t b, vertex_t c);
    vertex_q = {vertex_q, a, b, c};
  endtask

  // Wait out the results and any triangle still in flight.
  task automatic drain();
    while (vertex_q.size() != 0 || tangent_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    vertex_t a, b, c;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      a = rand_vertex(kind < 50); b = rand_vertex(kind < 50); c = rand_vertex(kind < 50);
      if (kind >= 90) begin
        // collinear uv: zero determinant
        b.tu = a.tu + 24'd7; b.tv = a.tv + 24'd3;
        c.tu = a.tu + 24'd14; c.tv = a.tv + 24'd6;
      end
      if (kind == 99) vertex_q = {vertex_q, rand_vertex(0)}; // break the triangle framing
      push_tri(a, b, c);
    end
  endtask

  initial begin
    vertex_t a, b, c;
    logic signed [TW-1:0] scales [6];
    corners = 0; scale_cfg = TW'(65536); offset_cfg = TW'(65536); cw_cfg = 1'b0;
    scales = '{24'sh7FFFFF, -24'sh800000, 24'sd1, -24'sd65536, 24'sd32768, 24'sd0};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, rounding, degenerate uvs, unused register index
    write_reg(REG_UV_OFFSET, 24'h123456);
    write_reg(cfg_reg_e'(2'd3), 24'hFFFFFF);
    a = '{tv: 24'h800000, tu: 24'h800000, pz: 32'h80000000, py: 32'h80000000,
          px: 32'h80000000};
    b = '{tv: 24'h800000, tu: 24'h7FFFFF, pz: 32'h7FFFFFFF, py: 32'h7FFFFFFF,
          px: 32'h7FFFFFFF};
    c = '{tv: 24'h7FFFFF, tu: 24'h800000, pz: 32'h7FFFFFFF, py: 32'h80000000,
          px: 32'h0};
    push_tri(a, b, c);
    push_tri(c, b, a);
    a = '{tv: 24'd0, tu: 24'd0, pz: 32'd0, py: 32'd0, px: 32'd0};
    b = '{tv: 24'd0, tu: 24'd3, pz: 32'd1, py: 32'd5, px: 32'd1};
    c = '{tv: 24'd2, tu: 24'd0, pz: 32'd3, py: 32'd1, px: 32'hFFFFFFFF};
    push_tri(a, b, c);
    push_tri(a, a, a);
    push_tri(a, b, b);
    b = '{tv: 24'd1, tu: 24'd1, pz: 32'h40000000, py: 32'h0, px: 32'h0};
    c = '{tv: 24'd1, tu: 24'd2, pz: 32'h0, py: 32'h40000000, px: 32'hC0000000};
    push_tri(a, b, c);
    push_tri(rand_vertex(0), rand_vertex(0), rand_vertex(0));
    drain();

    // random phases across scale, offset and winding settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_UV_SCALE, ph < 6 ? scales[ph] : TW'($urandom));
      write_reg(REG_UV_OFFSET, TW'($urandom));
      write_reg(REG_WINDING, TW'(ph % 2));
      random_phase(32);
      drain();
    end

    if (tangent_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
